// ----- hw/rtl/pcrc_pkg.sv -----
// Package for the packet checksum receive check unit.
// Holds the frame phase encoding and the result item type; no dependencies.
`default_nettype none

package pcrc_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned TsBytes   = 4;
    localparam int unsigned TsWidth   = TsBytes * ByteWidth;
    localparam int unsigned CkWidth   = 2 * ByteWidth;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_LEN  = 4'd1,
        PH_TS0  = 4'd2,
        PH_TS1  = 4'd3,
        PH_TS2  = 4'd4,
        PH_TS3  = 4'd5,
        PH_CK0  = 4'd6,
        PH_CK1  = 4'd7,
        PH_PAY  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [ByteWidth-1:0] payload_byte;
        logic                 payload_valid;
        logic                 frame_done;
        logic [ByteWidth-1:0] packet_id;
        logic [ByteWidth-1:0] payload_length;
        logic [TsWidth-1:0]   frame_timestamp;
        logic                 checksum_ok;
        logic                 aborted;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcrc_if.sv -----
// Valid/ready channel interfaces for the packet checksum receive check unit.
// Depends on pcrc_pkg for field widths.
`default_nettype none

interface pcrc_in_if;
    logic                           valid;
    logic                           ready;
    logic [pcrc_pkg::ByteWidth-1:0] rx_byte;
    logic                           frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface pcrc_out_if;
    logic                           valid;
    logic                           ready;
    logic [pcrc_pkg::ByteWidth-1:0] payload_byte;
    logic                           payload_valid;
    logic                           frame_done;
    logic [pcrc_pkg::ByteWidth-1:0] packet_id;
    logic [pcrc_pkg::ByteWidth-1:0] payload_length;
    logic [pcrc_pkg::TsWidth-1:0]   frame_timestamp;
    logic                           checksum_ok;
    logic                           aborted;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output packet_id, output payload_length,
                    output frame_timestamp, output checksum_ok, output aborted,
                    input ready);
    modport sink (input valid, input payload_byte, input payload_valid,
                  input frame_done, input packet_id, input payload_length,
                  input frame_timestamp, input checksum_ok, input aborted,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/packet_checksum_receive_check_unit.sv -----
// Top level of the packet checksum receive check unit.
// Depends on pcrc_pkg and the channel interfaces in pcrc_if.sv.
// Each result is registered: it enters the output register as its item is accepted.
// Throughput: one item per cycle unless stalled; two 8-bit adds into the result register.
// An item is accepted whenever the output register is empty or is being taken.
// Reset puts the frame phase in idle, clears the sums and header fields,
// and empties the output register.
`default_nettype none

module packet_checksum_receive_check_unit (
    input  wire          clk,
    input  wire          rst_n,
    pcrc_in_if.sink      in_ch,
    pcrc_out_if.source   out_ch
);

    localparam int unsigned BW = pcrc_pkg::ByteWidth;

    pcrc_pkg::phase_t            phase_reg, phase_next;
    logic [BW-1:0]               sum_low_reg, sum_low_next;
    logic [BW-1:0]               sum_high_reg, sum_high_next;
    logic [BW-1:0]               held_id_reg, held_id_next;
    logic [BW-1:0]               held_length_reg, held_length_next;
    logic [pcrc_pkg::TsWidth-1:0] held_ts_reg, held_ts_next;
    logic [pcrc_pkg::CkWidth-1:0] rx_check_reg, rx_check_next;
    logic [BW-1:0]               left_reg, left_next;

    pcrc_pkg::result_t           result_reg, result_next;
    logic                        out_valid_reg;
    logic                        has_result;

    logic                        accept;
    logic [BW-1:0]               b;
    logic [BW-1:0]               sl_add, sh_add;
    logic [pcrc_pkg::CkWidth-1:0] rx_check_full;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;

    assign sl_add        = sum_low_reg + b;
    assign sh_add        = sum_high_reg + sl_add;
    assign rx_check_full = {b, rx_check_reg[BW-1:0]};

    always_comb
    begin
        phase_next       = phase_reg;
        sum_low_next     = sum_low_reg;
        sum_high_next    = sum_high_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        held_ts_next     = held_ts_reg;
        rx_check_next    = rx_check_reg;
        left_next        = left_reg;
        has_result       = 1'b0;
        result_next      = '0;

        if (in_ch.frame_start)
        begin
            // A start in mid-frame closes the old frame as aborted.
            if (phase_reg != pcrc_pkg::PH_IDLE)
            begin
                has_result                  = 1'b1;
                result_next.frame_done      = 1'b1;
                result_next.packet_id       = held_id_reg;
                result_next.payload_length  = held_length_reg;
                result_next.frame_timestamp = held_ts_reg;
                result_next.aborted         = 1'b1;
            end
            sum_low_next     = b;
            sum_high_next    = b;
            held_id_next     = b;
            held_length_next = '0;
            held_ts_next     = '0;
            rx_check_next    = '0;
            left_next        = '0;
            phase_next       = pcrc_pkg::PH_LEN;
        end
        else
        begin
            unique case (phase_reg)
                pcrc_pkg::PH_IDLE:
                begin
                end
                pcrc_pkg::PH_LEN:
                begin
                    sum_low_next     = sl_add;
                    sum_high_next    = sh_add;
                    held_length_next = b;
                    left_next        = b;
                    phase_next       = pcrc_pkg::PH_TS0;
                end
                pcrc_pkg::PH_TS0:
                begin
                    sum_low_next      = sl_add;
                    sum_high_next     = sh_add;
                    held_ts_next[7:0] = b;
                    phase_next        = pcrc_pkg::PH_TS1;
                end
                pcrc_pkg::PH_TS1:
                begin
                    sum_low_next       = sl_add;
                    sum_high_next      = sh_add;
                    held_ts_next[15:8] = b;
                    phase_next         = pcrc_pkg::PH_TS2;
                end
                pcrc_pkg::PH_TS2:
                begin
                    sum_low_next        = sl_add;
                    sum_high_next       = sh_add;
                    held_ts_next[23:16] = b;
                    phase_next          = pcrc_pkg::PH_TS3;
                end
                pcrc_pkg::PH_TS3:
                begin
                    sum_low_next        = sl_add;
                    sum_high_next       = sh_add;
                    held_ts_next[31:24] = b;
                    phase_next          = pcrc_pkg::PH_CK0;
                end
                pcrc_pkg::PH_CK0:
                begin
                    rx_check_next = {{BW{1'b0}}, b};
                    phase_next    = pcrc_pkg::PH_CK1;
                end
                pcrc_pkg::PH_CK1:
                begin
                    rx_check_next = rx_check_full;
                    if (left_reg == '0)
                    begin
                        has_result                  = 1'b1;
                        result_next.frame_done      = 1'b1;
                        result_next.packet_id       = held_id_reg;
                        result_next.payload_length  = held_length_reg;
                        result_next.frame_timestamp = held_ts_reg;
                        result_next.checksum_ok     =
                            ({sum_high_reg, sum_low_reg} == rx_check_full);
                        phase_next                  = pcrc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = pcrc_pkg::PH_PAY;
                    end
                end
                pcrc_pkg::PH_PAY:
                begin
                    sum_low_next              = sl_add;
                    sum_high_next             = sh_add;
                    left_next                 = left_reg - 1'b1;
                    has_result                = 1'b1;
                    result_next.payload_byte  = b;
                    result_next.payload_valid = 1'b1;
                    if (left_reg == {{(BW-1){1'b0}}, 1'b1})
                    begin
                        result_next.frame_done      = 1'b1;
                        result_next.packet_id       = held_id_reg;
                        result_next.payload_length  = held_length_reg;
                        result_next.frame_timestamp = held_ts_reg;
                        result_next.checksum_ok     = ({sh_add, sl_add} == rx_check_reg);
                        phase_next                  = pcrc_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = pcrc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pcrc_pkg::PH_IDLE;
            sum_low_reg     <= '0;
            sum_high_reg    <= '0;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            held_ts_reg     <= '0;
            rx_check_reg    <= '0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                sum_low_reg     <= sum_low_next;
                sum_high_reg    <= sum_high_next;
                held_id_reg     <= held_id_next;
                held_length_reg <= held_length_next;
                held_ts_reg     <= held_ts_next;
                rx_check_reg    <= rx_check_next;
                left_reg        <= left_next;
                out_valid_reg   <= has_result;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.payload_byte    = result_reg.payload_byte;
    assign out_ch.payload_valid   = result_reg.payload_valid;
    assign out_ch.frame_done      = result_reg.frame_done;
    assign out_ch.packet_id       = result_reg.packet_id;
    assign out_ch.payload_length  = result_reg.payload_length;
    assign out_ch.frame_timestamp = result_reg.frame_timestamp;
    assign out_ch.checksum_ok     = result_reg.checksum_ok;
    assign out_ch.aborted         = result_reg.aborted;

    // A pending payload item that does not close its frame leaves the unit in payload.
    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.payload_valid && !result_reg.frame_done
        |-> phase_reg == pcrc_pkg::PH_PAY)
        else $error("payload item pending outside payload phase");

    // A pending verdict that was not an abort leaves the unit idle.
    a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.frame_done && !result_reg.aborted
        |-> phase_reg == pcrc_pkg::PH_IDLE)
        else $error("completed frame did not return to idle");

    // An abort verdict never carries payload or a passing checksum.
    a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.aborted
        |-> result_reg.frame_done && !result_reg.checksum_ok && !result_reg.payload_valid)
        else $error("malformed abort verdict");

    // An accepted start item always moves on to the length byte.
    a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.frame_start |=> phase_reg == pcrc_pkg::PH_LEN)
        else $error("frame start did not enter length phase");

endmodule

`default_nettype wire
